/* sv/pcnt_pkg.sv */
// Shared types and constants for the three-channel pulse counter.
package pcnt_pkg;

	localparam int unsigned CNT_W   = 16;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned PHASE_W = 8;
	localparam int unsigned LOCK_W  = 8;
	localparam int unsigned TPS_W   = 8;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CHAN_N  = 3;

	localparam int unsigned IN_W  = 8;
	localparam int unsigned OUT_W = 120;

	localparam logic [LOCK_W-1:0]  LOCK_RST  = 8'd8;
	localparam logic [TPS_W-1:0]   TPS_RST   = 8'd10;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd10;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		REG_LOCKOUT    = 2'd0,
		REG_TPS        = 2'd1,
		REG_IDLE_LIMIT = 2'd2
	} cfg_reg_t;

	// Per-transaction controls handed to each channel.
	typedef struct packed {
		logic en;        // transaction accepted this cycle
		logic clr;       // clear tally and idle count first
		logic pulse;     // edge seen while running
		logic boundary;  // second boundary while running
	} chan_ctl_t;

endpackage

/* sv/pcnt_chan.sv */
// One sensor channel: lockout check, tally, seen mark and idle-second count.
module pcnt_chan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcnt_pkg::chan_ctl_t                 ctl,
	input  logic [pcnt_pkg::TIME_W-1:0]         now_ticks,
	input  logic [pcnt_pkg::LOCK_W-1:0]         lockout_ticks,
	output logic                                accepted,
	output logic [pcnt_pkg::CNT_W-1:0]          tally_next,
	output logic [pcnt_pkg::CNT_W-1:0]          quiet_next
);
	import pcnt_pkg::*;

	logic [TIME_W-1:0] stamp_q;
	logic [CNT_W-1:0]  tally_q;
	logic [CNT_W-1:0]  quiet_q;
	logic              recent_q;

	logic [TIME_W-1:0] gap;
	logic [CNT_W-1:0]  tally_c;
	logic [CNT_W-1:0]  quiet_c;
	logic [CNT_W-1:0]  quiet_p;
	logic              recent_p;
	logic              recent_next;

	always_comb begin
		gap      = now_ticks - stamp_q;
		accepted = ctl.pulse && (gap > {{(TIME_W-LOCK_W){1'b0}}, lockout_ticks});
		tally_c  = ctl.clr ? '0 : tally_q;
		quiet_c  = ctl.clr ? '0 : quiet_q;
		tally_next = accepted ? tally_c + 1'b1 : tally_c;
		quiet_p  = accepted ? '0 : quiet_c;
		recent_p = accepted || recent_q;
		quiet_next  = quiet_p;
		recent_next = recent_p;
		if (ctl.boundary) begin
			// count a silent second, hold at full scale
			if (!recent_p && quiet_p != CNT_MAX) begin
				quiet_next = quiet_p + 1'b1;
			end
			recent_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			tally_q  <= '0;
			quiet_q  <= '0;
			recent_q <= 1'b0;
		end else if (ctl.en) begin
			if (accepted) begin
				stamp_q <= now_ticks;
			end
			tally_q  <= tally_next;
			quiet_q  <= quiet_next;
			recent_q <= recent_next;
		end
	end

endmodule

/* sv/three_channel_pulse_counter_idle_top.sv */
// Top level of the three-channel pulse counter with lockout and idle timeout.
// An accepted input transaction has its result in the output register in the next cycle.
// Throughput: one transaction per cycle while the receiver takes each result; the output register frees as it is taken.
// State update and result are formed together by the channel and tick logic.
// Reset (arst_n low) clears all counters, stamps and marks and loads register defaults.
module three_channel_pulse_counter_idle_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [0] tick, [1] pulse_r, [2] pulse_f, [3] pulse_l, [4] running,
	// [5] clear_counts, [6] arm_stop, [7] zero
	input  logic [pcnt_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] count_r, [31:16] count_f, [47:32] count_l, [63:48] idle_secs_r,
	// [79:64] idle_secs_f, [95:80] idle_secs_l, [98:96] accepted_mask,
	// [99] stop_request, [115:100] time_ticks, [116] second_mark, [119:117] zero
	output logic [pcnt_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [pcnt_pkg::CFG_W-1:0]   cfg_data
);
	import pcnt_pkg::*;

	logic [LOCK_W-1:0]  lockout_q;
	logic [TPS_W-1:0]   tps_q;
	logic [LIMIT_W-1:0] limit_q;

	logic [TIME_W-1:0]  now_q;
	logic [PHASE_W-1:0] phase_q;
	logic               armed_q;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic        accept;
	logic        in_tick, in_running, in_clr, in_arm;
	logic [2:0]  in_pulse;
	logic [PHASE_W:0] limit_ext;
	logic [PHASE_W:0] phase_inc;
	logic        mark;
	logic        boundary;
	logic [TIME_W-1:0]  now_next;
	logic [PHASE_W-1:0] phase_next;
	logic        armed_c;
	logic        all_idle;
	logic        stop;

	chan_ctl_t   ctl [CHAN_N];
	logic [CHAN_N-1:0] acc_mask;
	logic [CNT_W-1:0]  tally_n [CHAN_N];
	logic [CNT_W-1:0]  quiet_n [CHAN_N];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_tick    = s_axis_tdata[0];
	assign in_pulse   = s_axis_tdata[3:1];
	assign in_running = s_axis_tdata[4];
	assign in_clr     = s_axis_tdata[5];
	assign in_arm     = s_axis_tdata[6];

	always_comb begin
		// zero ticks-per-second means a 256-tick second
		limit_ext  = (tps_q == '0) ? {1'b1, {PHASE_W{1'b0}}} : {1'b0, tps_q};
		phase_inc  = {1'b0, phase_q} + 1'b1;
		mark       = in_tick && (phase_inc >= limit_ext);
		boundary   = mark && in_running;
		now_next   = now_q + {{(TIME_W-1){1'b0}}, in_tick};
		phase_next = phase_q;
		if (in_tick) begin
			phase_next = mark ? '0 : phase_inc[PHASE_W-1:0];
		end
	end

	for (genvar i = 0; i < CHAN_N; i++) begin : g_chan
		assign ctl[i] = '{en: accept, clr: in_clr, pulse: in_running && in_pulse[i],
			boundary: boundary};
		pcnt_chan u_chan (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl[i]),
			.now_ticks     (now_q),
			.lockout_ticks (lockout_q),
			.accepted      (acc_mask[i]),
			.tally_next    (tally_n[i]),
			.quiet_next    (quiet_n[i])
		);
	end

	always_comb begin
		armed_c  = armed_q || in_arm;
		all_idle = (quiet_n[0] > limit_q) && (quiet_n[1] > limit_q) && (quiet_n[2] > limit_q);
		stop     = boundary && armed_c && all_idle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCK_RST;
			tps_q     <= TPS_RST;
			limit_q   <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOCKOUT:    lockout_q <= cfg_data[LOCK_W-1:0];
				REG_TPS:        tps_q     <= cfg_data[TPS_W-1:0];
				REG_IDLE_LIMIT: limit_q   <= cfg_data[LIMIT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			phase_q <= '0;
			armed_q <= 1'b0;
		end else if (accept) begin
			now_q   <= now_next;
			phase_q <= phase_next;
			armed_q <= armed_c && !stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000, mark, now_next, stop, acc_mask,
				quiet_n[2], quiet_n[1], quiet_n[0], tally_n[2], tally_n[1], tally_n[0]};
		end
	end

	// a stop is only raised on a second boundary
	a_stop_on_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[99] |-> m_axis_tdata[116])
		else $error("stop_request without second_mark");

	// raising a stop drops the arm
	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stop |=> !armed_q)
		else $error("arm still set after stop");

	// time advances only on ticks
	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_tick |=> $stable(now_q))
		else $error("time moved without a tick");

	// an accepted pulse on channel r leaves that channel with zero idle seconds
	a_pulse_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[63:48] == '0)
		else $error("idle count nonzero after accepted pulse");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the three-channel pulse counter with lockout and idle timeout.
`timescale 1ns / 100ps

module tb_top;
	import pcnt_pkg::*;

	localparam int unsigned RUN_LIMIT   = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 300;

	// Input transaction, tick in bit 0.
	typedef struct packed {
		logic pad;
		logic arm_stop;
		logic clear_counts;
		logic running;
		logic pulse_l;
		logic pulse_f;
		logic pulse_r;
		logic tick;
	} sensor_event_t;

	// Output transaction, count_r in the lowest bits.
	typedef struct packed {
		logic [2:0]       pad;
		logic             second_mark;
		logic [TIME_W-1:0] time_ticks;
		logic             stop_request;
		logic [2:0]       accepted_mask;
		logic [CNT_W-1:0] idle_secs_l;
		logic [CNT_W-1:0] idle_secs_f;
		logic [CNT_W-1:0] idle_secs_r;
		logic [CNT_W-1:0] count_l;
		logic [CNT_W-1:0] count_f;
		logic [CNT_W-1:0] count_r;
	} counter_reading_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_LOCKOUT;
	logic [CFG_W-1:0] cfg_data = '0;

	three_channel_pulse_counter_idle_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the counter state and registers.
	logic [LOCK_W-1:0]  cfg_lockout = LOCK_RST;
	logic [TPS_W-1:0]   cfg_tps     = TPS_RST;
	logic [LIMIT_W-1:0] cfg_limit   = LIMIT_RST;
	logic [TIME_W-1:0]  clock_ticks = '0;
	logic [PHASE_W-1:0] sec_phase   = '0;
	logic [TIME_W-1:0]  last_hit  [CHAN_N] = '{default: '0};
	logic [CNT_W-1:0]   hits      [CHAN_N] = '{default: '0};
	logic [CNT_W-1:0]   idle_secs [CHAN_N] = '{default: '0};
	logic [CHAN_N-1:0]  seen  = '0;
	logic               armed = 1'b0;

	counter_reading_t readings_due [$];

	logic        steady_flow = 1'b0;
	logic        rx_hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned events_sent = 0;
	int unsigned settings_used = 0;
	int unsigned stops_seen = 0;
	int unsigned marks_seen = 0;
	int unsigned pulses_taken = 0;

	task automatic predict_reading(input sensor_event_t ev);
		counter_reading_t r;
		logic [2:0]        edges;
		logic [2:0]        took;
		logic [TIME_W-1:0] gap;
		logic [8:0]        span;
		logic [8:0]        nxt;
		logic              boundary;
		logic              stop_now;
		logic              all_idle;
		r = '0;
		edges = {ev.pulse_l, ev.pulse_f, ev.pulse_r};
		took = '0;
		boundary = 1'b0;
		stop_now = 1'b0;
		if (ev.clear_counts) begin
			for (int ch = 0; ch < CHAN_N; ch++) begin
				hits[ch] = '0;
				idle_secs[ch] = '0;
			end
		end
		if (ev.arm_stop)
			armed = 1'b1;
		if (ev.running) begin
			for (int ch = 0; ch < CHAN_N; ch++) begin
				gap = clock_ticks - last_hit[ch];
				if (edges[ch] && gap > cfg_lockout) begin
					last_hit[ch] = clock_ticks;
					hits[ch] = hits[ch] + 1'b1;
					seen[ch] = 1'b1;
					idle_secs[ch] = '0;
					took[ch] = 1'b1;
				end
			end
		end
		if (ev.tick) begin
			// a zero rate means 256 ticks per second
			span = (cfg_tps == '0) ? 9'd256 : {1'b0, cfg_tps};
			nxt = {1'b0, sec_phase} + 9'd1;
			clock_ticks = clock_ticks + 1'b1;
			if (nxt >= span) begin
				sec_phase = '0;
				boundary = 1'b1;
			end else begin
				sec_phase = nxt[PHASE_W-1:0];
			end
			if (boundary && ev.running) begin
				all_idle = 1'b1;
				for (int ch = 0; ch < CHAN_N; ch++) begin
					if (!seen[ch] && idle_secs[ch] != CNT_MAX)
						idle_secs[ch] = idle_secs[ch] + 1'b1;
					seen[ch] = 1'b0;
					if (idle_secs[ch] <= cfg_limit)
						all_idle = 1'b0;
				end
				if (armed && all_idle) begin
					stop_now = 1'b1;
					armed = 1'b0;
				end
			end
		end
		r.count_r = hits[0];
		r.count_f = hits[1];
		r.count_l = hits[2];
		r.idle_secs_r = idle_secs[0];
		r.idle_secs_f = idle_secs[1];
		r.idle_secs_l = idle_secs[2];
		r.accepted_mask = took;
		r.stop_request = stop_now;
		r.time_ticks = clock_ticks;
		r.second_mark = boundary;
		readings_due.push_back(r);
	endtask

	function automatic sensor_event_t make_event(input bit tick, input bit [2:0] pulses,
			input bit running, input bit clr, input bit arm);
		sensor_event_t ev;
		ev = '0;
		ev.tick = tick;
		{ev.pulse_l, ev.pulse_f, ev.pulse_r} = pulses;
		ev.running = running;
		ev.clear_counts = clr;
		ev.arm_stop = arm;
		return ev;
	endfunction

	function automatic sensor_event_t random_event(input int unsigned pulse_pct);
		sensor_event_t ev;
		ev = '0;
		ev.tick = $urandom_range(99) < 75;
		ev.pulse_r = $urandom_range(99) < pulse_pct;
		ev.pulse_f = $urandom_range(99) < pulse_pct;
		ev.pulse_l = $urandom_range(99) < pulse_pct;
		ev.running = $urandom_range(99) < 90;
		ev.clear_counts = $urandom_range(99) < 3;
		ev.arm_stop = $urandom_range(99) < 15;
		return ev;
	endfunction

	task automatic send_event(input sensor_event_t ev);
		s_axis_tdata  <= ev;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_reading(ev);
		events_sent++;
		if (!steady_flow && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (readings_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(input logic [LOCK_W-1:0] lockout, input logic [TPS_W-1:0] tps,
			input logic [LIMIT_W-1:0] limit);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOCKOUT;
		cfg_data  <= CFG_W'(lockout);
		@(posedge clk);
		cfg_lockout = lockout;
		cfg_index <= REG_TPS;
		cfg_data  <= CFG_W'(tps);
		@(posedge clk);
		cfg_tps = tps;
		cfg_index <= REG_IDLE_LIMIT;
		cfg_data  <= CFG_W'(limit);
		@(posedge clk);
		cfg_limit = limit;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(input logic [LOCK_W-1:0] lockout, input logic [TPS_W-1:0] tps,
			input logic [LIMIT_W-1:0] limit, input int unsigned count);
		int unsigned pulse_pct;
		set_config(lockout, tps, limit);
		pulse_pct = 40;
		for (int unsigned n = 0; n < count; n++) begin
			// switch between silent spells, sparse and busy sensors
			if (n % 20 == 0) begin
				case ($urandom_range(2))
					0: pulse_pct = 0;
					1: pulse_pct = 5;
					default: pulse_pct = 40;
				endcase
			end
			send_event(random_event(pulse_pct));
		end
	endtask

	task automatic test_directed_basics();
		send_event(make_event(0, 3'b000, 0, 0, 0));
		send_event(make_event(1, 3'b111, 0, 0, 0));   // stopped: pulses dropped
		send_event(make_event(0, 3'b111, 1, 0, 0));   // inside the lockout
		repeat (8) send_event(make_event(1, 3'b000, 1, 0, 0));
		send_event(make_event(0, 3'b111, 1, 0, 0));   // gap just past the lockout
		send_event(make_event(1, 3'b001, 1, 0, 0));   // second boundary with seen channels
		send_event(make_event(0, 3'b010, 1, 1, 1));   // clear and arm together
	endtask

	task automatic test_config_extremes();
		set_config(8'd0, 8'd1, 16'd0);
		send_event(make_event(0, 3'b001, 1, 0, 0));
		send_event(make_event(0, 3'b001, 1, 0, 0));   // same tick: zero gap rejected
		send_event(make_event(1, 3'b000, 1, 0, 1));
		send_event(make_event(1, 3'b000, 1, 0, 0));   // all idle past limit: stop
		send_event(make_event(1, 3'b000, 1, 0, 0));   // arm already spent
		send_event(make_event(1, 3'b000, 0, 0, 1));   // boundary while stopped
		send_event(make_event(0, 3'b000, 1, 0, 0));
		send_event(make_event(1, 3'b111, 1, 0, 0));
	endtask

	task automatic test_random_traffic();
		random_phase(8'd8,   8'd10,  16'd10,    160);
		random_phase(8'd0,   8'd1,   16'd0,     160);
		random_phase(8'd3,   8'd2,   16'd1,     160);
		random_phase(8'd255, 8'd255, 16'd65535, 180);
		// phase left high by the slow rate runs past the new rate
		random_phase(8'd2,   8'd3,   16'd2,     160);
		random_phase(8'd255, 8'd0,   16'd3,     280);
		random_phase(8'd20,  8'd4,   16'd65534, 165);
	endtask

	task automatic test_backpressure();
		set_config(8'd4, 8'd2, 16'd1);
		rx_hold_req <= 1'b1;
		repeat (120) send_event(random_event(20));
	endtask

	task automatic test_steady_seconds();
		set_config(8'd0, 8'd1, 16'd30);
		steady_flow = 1'b1;
		send_event(make_event(0, 3'b000, 1, 1, 1));
		// every tick is a second: idle counts climb past the limit with no gaps
		repeat (40) send_event(make_event(1, 3'b000, 1, 0, 0));
		send_event(make_event(1, 3'b111, 1, 0, 0));
		send_event(make_event(1, 3'b000, 1, 0, 1));
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_basics();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		test_steady_seconds();
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Covered %0d sensor events over %0d register settings.",
			events_sent, settings_used);
		$display("Saw %0d accepted pulses, %0d second marks, %0d stop requests.",
			pulses_taken, marks_seen, stops_seen);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random ready, plus one long hold on request.
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req <= 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady_flow || ($urandom_range(99) >= 17);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		counter_reading_t got;
		counter_reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (readings_due.size() == 0) begin
				$error("reading with no pending sensor event: %h", got);
				mismatches++;
			end else begin
				want = readings_due.pop_front();
				check_field("count_r", want.count_r, got.count_r);
				check_field("count_f", want.count_f, got.count_f);
				check_field("count_l", want.count_l, got.count_l);
				check_field("idle_secs_r", want.idle_secs_r, got.idle_secs_r);
				check_field("idle_secs_f", want.idle_secs_f, got.idle_secs_f);
				check_field("idle_secs_l", want.idle_secs_l, got.idle_secs_l);
				check_field("accepted_mask", want.accepted_mask, got.accepted_mask);
				check_field("stop_request", want.stop_request, got.stop_request);
				check_field("time_ticks", want.time_ticks, got.time_ticks);
				check_field("second_mark", want.second_mark, got.second_mark);
				stops_seen += want.stop_request;
				marks_seen += want.second_mark;
				pulses_taken += $countones(want.accepted_mask);
			end
		end
	end

	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d readings outstanding.",
			cycles, readings_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
